@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/etfe_pkg.sv @@
// ----------------------------------------------------------------------------
// etfe_pkg
// types and constants for the epoch time field extractor
// ----------------------------------------------------------------------------
package etfe_pkg;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NULL          = 2'd1;
  localparam logic [1:0] ST_NOT_SUPPORTED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW      = 2'd3;

  localparam logic [1:0] CMD_YEAR  = 2'd0;
  localparam logic [1:0] CMD_MONTH = 2'd1;
  localparam logic [1:0] CMD_DAY   = 2'd2;
  localparam logic [1:0] CMD_HOUR  = 2'd3;

  localparam logic [1:0] KIND_DATE = 2'd0;
  localparam logic [1:0] KIND_TS   = 2'd1;

  // microseconds per hour over 2^10
  localparam logic [21:0] DIV_HOUR   = 22'd3515625;
  // days per 400-year era
  localparam logic [17:0] DIV_ERA    = 18'd146097;
  localparam logic [32:0] DAY_SHIFT  = 33'd719468;
  localparam logic [31:0] EPOCH_YEAR = 32'd1970;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_date;
    logic [1:0]  status;
    logic [31:0] hour;
    logic [31:0] days;
  } side_t;

endpackage

@@ sv/epoch_time_field_extract_top.sv @@
// ----------------------------------------------------------------------------
// epoch_time_field_extract_top
// throughput: one request per cycle, stalls only when the output skid is full
// reset: rst clears every valid bit and the skid stage, data registers keep
// extracts year, month, day or hour counts since 1970 from a date or a
// microsecond timestamp, floor rounding, gregorian calendar
// ----------------------------------------------------------------------------
module epoch_time_field_extract_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value
  input  logic [5:0]  s_tuser,   // cmd, value_kind, is_null, is_bound_marker
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // field_value
  output logic [1:0]  m_tuser    // status
);
  import etfe_pkg::*;

  localparam int K3 = 31;
  localparam logic [63:0] M3 = ((64'd1 << K3) + 64'd2) / 64'd3;
  localparam int K1460 = 29;
  localparam logic [63:0] M1460 = ((64'd1 << K1460) + 64'd1459) / 64'd1460;
  localparam int K36524 = 34;
  localparam logic [63:0] M36524 = ((64'd1 << K36524) + 64'd36523) / 64'd36524;
  localparam int K146096 = 36;
  localparam logic [63:0] M146096 = ((64'd1 << K146096) + 64'd146095) / 64'd146096;
  localparam int K365 = 27;
  localparam logic [63:0] M365 = ((64'd1 << K365) + 64'd364) / 64'd365;
  localparam int K100 = 16;
  localparam logic [63:0] M100 = ((64'd1 << K100) + 64'd99) / 64'd100;
  localparam int K153 = 19;
  localparam logic [63:0] M153 = ((64'd1 << K153) + 64'd152) / 64'd153;

  function automatic logic [53:0] hdiv4(input logic [21:0] r, input logic [31:0] w);
    logic [22:0] t;
    logic [21:0] rr;
    logic [31:0] ww;
    rr = r;
    ww = w;
    for (int i = 0; i < 4; i++) begin
      t = {rr, ww[31]};
      if (t >= {1'b0, DIV_HOUR}) begin
        rr = 22'(t - {1'b0, DIV_HOUR});
        ww = {ww[30:0], 1'b1};
      end else begin
        rr = t[21:0];
        ww = {ww[30:0], 1'b0};
      end
    end
    return {rr, ww};
  endfunction

  function automatic logic [33:0] ediv4(input logic [17:0] r, input logic [15:0] w);
    logic [18:0] t;
    logic [17:0] rr;
    logic [15:0] ww;
    rr = r;
    ww = w;
    for (int i = 0; i < 4; i++) begin
      t = {rr, ww[15]};
      if (t >= {1'b0, DIV_ERA}) begin
        rr = 18'(t - {1'b0, DIV_ERA});
        ww = {ww[14:0], 1'b1};
      end else begin
        rr = t[17:0];
        ww = {ww[14:0], 1'b0};
      end
    end
    return {rr, ww};
  endfunction

  logic        en;
  logic        v  [0:23];
  side_t       sd [0:23];

  logic [21:0] h_r [0:8];
  logic [31:0] h_w [0:8];
  logic        h_n [0:8];

  logic [63:0] p9;
  logic        n9;
  logic [17:0] e_r [10:14];
  logic [15:0] e_w [10:14];
  logic        e_n [10:14];

  logic [16:0] era15, era16, era17, era18, era19, era20, era21;
  logic [17:0] doe15, doe16, doe17, doe18, doe19;
  logic [55:0] pa16, pb16, pc16;
  logic [17:0] n17;
  logic [47:0] p18;
  logic [8:0]  yoe19, yoe20, yoe21;
  logic [31:0] p19;
  logic [8:0]  doy20;
  logic [31:0] p21;
  logic [25:0] era400_22;
  logic [9:0]  yy22;
  logic [3:0]  m22;
  logic [31:0] res23;

  logic        o_valid;
  logic [31:0] o_res;
  logic [1:0]  o_status;
  logic        skid_valid;
  logic [31:0] skid_res;
  logic [1:0]  skid_status;

  // input decode
  logic [1:0]  in_cmd, in_kind;
  logic        in_null, in_bound;
  side_t       side0_next;
  logic [52:0] u0;

  always_comb begin
    in_cmd   = s_tuser[1:0];
    in_kind  = s_tuser[3:2];
    in_null  = s_tuser[4];
    in_bound = s_tuser[5];
    side0_next.cmd     = in_cmd;
    side0_next.is_date = (in_kind == KIND_DATE);
    side0_next.hour    = '0;
    side0_next.days    = s_tdata[31:0];
    if (in_null) begin
      side0_next.status = ST_NULL;
    end else if (in_bound || (in_kind != KIND_DATE && in_kind != KIND_TS)) begin
      side0_next.status = ST_NOT_SUPPORTED;
    end else if (in_kind == KIND_DATE && in_cmd == CMD_HOUR) begin
      side0_next.status = ST_NOT_SUPPORTED;
    end else begin
      side0_next.status = ST_OK;
    end
    u0 = s_tdata[63] ? ~s_tdata[62:10] : s_tdata[62:10];
  end

  // hour count and timestamp day count
  logic [32:0] hq;
  logic [28:0] u9;
  side_t       side9_next;

  always_comb begin
    hq = h_n[8] ? ~{1'b0, h_w[8]} : {1'b0, h_w[8]};
    u9 = hq[32] ? ~hq[31:3] : hq[31:3];
    side9_next = sd[8];
    side9_next.hour = hq[31:0];
    if (sd[8].status == ST_OK && !sd[8].is_date && sd[8].cmd == CMD_HOUR &&
        (hq[32] != hq[31])) begin
      side9_next.status = ST_OVERFLOW;
    end
  end

  logic [28:0] dts;
  logic [32:0] z10;
  logic [31:0] u10;
  side_t       side10_next;

  always_comb begin
    dts = n9 ? ~{1'b0, p9[58:31]} : {1'b0, p9[58:31]};
    side10_next = sd[9];
    if (!sd[9].is_date) begin
      side10_next.days = {{3{dts[28]}}, dts};
    end
    z10 = {side10_next.days[31], side10_next.days} + DAY_SHIFT;
    u10 = z10[32] ? ~z10[31:0] : z10[31:0];
  end

  // valid and sideband chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 24; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= s_tvalid;
      for (int i = 1; i < 24; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side0_next;
      for (int i = 1; i < 24; i++) begin
        if (i == 9) begin
          sd[i] <= side9_next;
        end else if (i == 10) begin
          sd[i] <= side10_next;
        end else begin
          sd[i] <= sd[i-1];
        end
      end
    end
  end

  // division chains
  always_ff @(posedge clk) begin
    logic [53:0] hs;
    logic [33:0] es;
    if (en) begin
      h_r[0] <= {1'b0, u0[52:32]};
      h_w[0] <= u0[31:0];
      h_n[0] <= s_tdata[63];
      for (int i = 1; i < 9; i++) begin
        hs = hdiv4(h_r[i-1], h_w[i-1]);
        h_r[i] <= hs[53:32];
        h_w[i] <= hs[31:0];
        h_n[i] <= h_n[i-1];
      end
      p9 <= 64'(u9) * M3;
      n9 <= hq[32];
      e_r[10] <= {2'b0, u10[31:16]};
      e_w[10] <= u10[15:0];
      e_n[10] <= z10[32];
      for (int i = 11; i < 15; i++) begin
        es = ediv4(e_r[i-1], e_w[i-1]);
        e_r[i] <= es[33:16];
        e_w[i] <= es[15:0];
        e_n[i] <= e_n[i-1];
      end
    end
  end

  // civil date stages
  logic [17:0] doy_full;
  logic [10:0] x21;
  logic [3:0]  mp22, m22_next;
  logic [31:0] year23, month23;

  always_comb begin
    doy_full = doe19 - 18'(18'(yoe19) * 18'd365) - 18'(yoe19[8:2]) + 18'(p19[24:16]);
    x21 = 11'(11'(doy20) * 11'd5) + 11'd2;
    mp22 = p21[22:19];
    m22_next = (mp22 < 4'd10) ? mp22 + 4'd3 : mp22 - 4'd9;
    year23 = {{6{era400_22[25]}}, era400_22} + 32'(yy22) - EPOCH_YEAR;
    month23 = (year23 << 3) + (year23 << 2) + 32'(m22) - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      era15 <= e_n[14] ? ~{1'b0, e_w[14]} : {1'b0, e_w[14]};
      doe15 <= e_n[14] ? DIV_ERA - 18'd1 - e_r[14] : e_r[14];
      era16 <= era15;
      doe16 <= doe15;
      pa16  <= 56'(doe15) * 56'(M1460);
      pb16  <= 56'(doe15) * 56'(M36524);
      pc16  <= 56'(doe15) * 56'(M146096);
      era17 <= era16;
      doe17 <= doe16;
      n17   <= doe16 - pa16[46:29] + pb16[51:34] - pc16[53:36];
      era18 <= era17;
      doe18 <= doe17;
      p18   <= 48'(n17) * 48'(M365);
      era19 <= era18;
      doe19 <= doe18;
      yoe19 <= p18[35:27];
      p19   <= 32'(p18[35:27]) * 32'(M100);
      era20 <= era19;
      yoe20 <= yoe19;
      doy20 <= doy_full[8:0];
      era21 <= era20;
      yoe21 <= yoe20;
      p21   <= 32'(x21) * 32'(M153);
      era400_22 <= {{9{era21[16]}}, era21} * 26'd400;
      yy22  <= 10'(yoe21) + ((m22_next <= 4'd2) ? 10'd1 : 10'd0);
      m22   <= m22_next;
      if (sd[22].status != ST_OK) begin
        res23 <= '0;
      end else begin
        case (sd[22].cmd)
          CMD_YEAR:  res23 <= year23;
          CMD_MONTH: res23 <= month23;
          CMD_DAY:   res23 <= sd[22].days;
          default:   res23 <= sd[22].hour;
        endcase
      end
    end
  end

  // the era path feeds the stage 22 multiply by 400
  // (era15..era21 carry the era alongside)

  // output register and skid
  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        o_res      <= skid_res;
        o_status   <= skid_status;
        skid_valid <= 1'b0;
      end
    end else if (!o_valid || m_tready) begin
      o_valid  <= v[23];
      o_res    <= res23;
      o_status <= sd[23].status;
    end else if (v[23]) begin
      skid_valid  <= 1'b1;
      skid_res    <= res23;
      skid_status <= sd[23].status;
    end
  end

  assign s_tready = en;
  assign m_tvalid = o_valid;
  assign m_tdata  = o_res;
  assign m_tuser  = o_status;

`include "assert_macros.svh"

  `ASSERT_CLK(a_skid_needs_out, skid_valid |-> o_valid, "skid holds data with output empty")
  `ASSERT_CLK(a_skid_on_stall, $rose(skid_valid) |-> $past(o_valid && !m_tready), "skid filled without stall")
  `ASSERT_CLK(a_bad_status_zero, (o_valid && o_status != ST_OK) |-> (o_res == 32'd0), "nonzero data on error")
  `ASSERT_ALWAYS(a_reset_clears, rst |=> (!o_valid && !skid_valid), "reset left output valid")

endmodule

@@ verif/epoch_time_field_extract_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_time_field_extract_top_tb
// checks year, month, day and hour extraction against a gregorian predictor,
// with directed edge values, random dates and timestamps, bursty input and a
// stalling output side
// ----------------------------------------------------------------------------
module epoch_time_field_extract_top_tb;
  import etfe_pkg::*;

  localparam longint US_DAY  = 64'sd86400000000;
  localparam longint US_HOUR = 64'sd3600000000;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [31:0] field_value;
    logic [1:0]  status;
  } part_t;

  class part_scoreboard;
    part_t pending[$];
    int    errors;

    function longint fdiv(longint v, longint d);
      longint q;
      q = v / d;
      if ((v % d) != 0 && v < 0) q -= 1;
      return q;
    endfunction

    function part_t extract(logic [1:0] cmd, logic [1:0] kind, logic [63:0] raw,
                            logic nul, logic bnd);
      part_t  p;
      longint days, us, h, z, era, doe, yoe, doy, mp, m, y, res;
      p.status = ST_OK;
      res = 0;
      days = 0;
      if (nul) p.status = ST_NULL;
      else if (bnd || kind > KIND_TS) p.status = ST_NOT_SUPPORTED;
      else if (kind == KIND_DATE) begin
        days = longint'($signed(raw[31:0]));
        if (cmd == CMD_HOUR) p.status = ST_NOT_SUPPORTED;
      end else begin
        us = $signed(raw);
        if (cmd == CMD_HOUR) begin
          h = fdiv(us, US_HOUR);
          if (h < -64'sd2147483648 || h > 64'sd2147483647) p.status = ST_OVERFLOW;
          else res = h;
        end else days = fdiv(us, US_DAY);
      end
      if (p.status == ST_OK && cmd != CMD_HOUR) begin
        if (cmd == CMD_DAY) res = days;
        else begin
          z = days + 719468;
          era = fdiv(z, 146097);
          doe = z - era * 146097;
          yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
          doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
          mp = (5 * doy + 2) / 153;
          m = (mp < 10) ? mp + 3 : mp - 9;
          y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
          res = (cmd == CMD_YEAR) ? y - 1970 : (y - 1970) * 12 + (m - 1);
        end
      end
      p.field_value = res[31:0];
      return p;
    endfunction

    function void note_request(logic [63:0] data, logic [5:0] user);
      pending.push_back(extract(user[1:0], user[3:2], data, user[4], user[5]));
    endfunction

    function void check_result(logic [31:0] fv, logic [1:0] st);
      part_t e;
      if (pending.size() == 0) begin
        $error("unexpected result field_value %0d status %0d", $signed(fv), st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (fv !== e.field_value) begin
        $error("field_value expected %0d actual %0d", $signed(e.field_value), $signed(fv));
        errors++;
      end
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [5:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  part_scoreboard sb = new();
  int  burst_left = 0;
  bit  long_hold = 1'b0;

  epoch_time_field_extract_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (long_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_request(logic [1:0] cmd, logic [1:0] kind, logic [63:0] v,
                              logic nul, logic bnd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tdata  <= v;
    s_tuser  <= {bnd, nul, kind, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [63:0] rand_value(logic [1:0] kind);
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = {{32{$urandom_range(0, 1) == 1}}, $urandom};
      2: v = longint'($signed(32'($urandom_range(0, 200000)))) - 100000;
      3: v = (longint'($urandom_range(0, 300000)) - 150000) * US_DAY
             + $urandom_range(0, 2) - 1;
      default: v = (longint'($signed($urandom))) * US_HOUR + $urandom_range(0, 2) - 1;
    endcase
    if (kind == KIND_DATE && $urandom_range(0, 1)) v = {$urandom, v[31:0]};
    return v;
  endfunction

  initial begin
    logic [1:0] k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int c = 0; c < 4; c++) begin
      send_request(2'(c), KIND_DATE, 64'd0, 1'b0, 1'b0);
      send_request(2'(c), KIND_DATE, 64'h0000_0000_7fff_ffff, 1'b0, 1'b0);
      send_request(2'(c), KIND_DATE, 64'hffff_ffff_8000_0000, 1'b0, 1'b0);
      send_request(2'(c), KIND_TS, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
      send_request(2'(c), KIND_TS, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
      send_request(2'(c), KIND_TS, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    end
    send_request(CMD_YEAR, KIND_TS, 64'd5, 1'b1, 1'b1);
    send_request(CMD_DAY, KIND_DATE, 64'd5, 1'b0, 1'b1);
    send_request(CMD_MONTH, KIND_OTHER, 64'd5, 1'b0, 1'b0);
    send_request(CMD_HOUR, KIND_SPARE, 64'd5, 1'b0, 1'b0);
    send_request(CMD_HOUR, KIND_TS, 64'sd2147483648 * US_HOUR, 1'b0, 1'b0);
    send_request(CMD_HOUR, KIND_TS, -64'sd2147483648 * US_HOUR, 1'b0, 1'b0);
    send_request(CMD_HOUR, KIND_TS, -64'sd2147483648 * US_HOUR - 1, 1'b0, 1'b0);
    for (int i = 0; i < 1600; i++) begin
      if (i == 400) begin
        long_hold = 1'b1;
        fork
          begin repeat (200) @(posedge clk); long_hold = 1'b0; end
        join_none
      end
      if (i == 900) begin
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      k = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      send_request(2'($urandom_range(0, 3)), k, rand_value(k),
                   $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
    end
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
